FILE: design/gsm7_pkg.sv
// Shared types and constants for the GSM 7-bit septet unpacker.
`default_nettype none
package gsm7_pkg;

  localparam int MAX_SEPTETS_DEF = 4096;
  localparam int MAX_RES         = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int CHAR_W          = 8;
  localparam int SEPT_W          = 7;
  localparam int COUNT_W         = 13;

  localparam logic [SEPT_W-1:0]   CR_CHAR       = 7'h0D;
  localparam logic [COUNT_W-1:0]  LIMIT_RST     = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_OFFSET  = 2'd0,
    CFG_USSD_MODE    = 2'd1,
    CFG_SEPTET_LIMIT = 2'd2,
    CFG_TERMINATOR   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               char_valid;
    logic [COUNT_W-1:0] septet_count;
    logic               final_res;
  } res_t;

endpackage
`default_nettype wire

FILE: design/gsm7_septet_unpacker_top.sv
// Top level of the GSM 7-bit septet unpacker: octets in, characters out.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_octet, in_last_octet
//  out_     output     out_valid / out_ready  out_character, out_char_valid,
//                                             out_septet_count, out_final_res
//  cfg_     input      cfg_we                 cfg_addr, cfg_wdata
//
// An octet is decoded in the cycle it is accepted; its 0..4 result beats leave
// one per cycle while out_ready is high: one beat for most octets, two when a
// carried septet completes, up to four on a last octet. The next octet is
// taken in the cycle the last buffered beat is taken; a low out_ready holds
// in_ready low while any beat is pending. rst_n is synchronous and starts a
// fresh message with registers at their reset values.
`default_nettype none
module gsm7_septet_unpacker_top #(
  parameter int MAX_SEPTETS = gsm7_pkg::MAX_SEPTETS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [gsm7_pkg::CHAR_W-1:0]      in_octet,
  input  wire logic                             in_last_octet,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [gsm7_pkg::CHAR_W-1:0]           out_character,
  output logic                                  out_char_valid,
  output logic [gsm7_pkg::COUNT_W-1:0]          out_septet_count,
  output logic                                  out_final_res,
  input  wire logic                             cfg_we,
  input  wire logic [gsm7_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [gsm7_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gsm7_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEPTETS + 1);
  localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_SEPTETS);
  localparam int RCNT_W = $clog2(MAX_RES + 1);
  localparam int RIDX_W = $clog2(MAX_RES);

  // configuration
  logic [2:0]          fill_offset_r;
  logic                ussd_mode_r;
  logic [COUNT_W-1:0]  septet_limit_r;
  logic [CHAR_W-1:0]   terminator_r;

  // message state
  logic [2:0]          budget_r, budget_nxt;
  logic                first_r, first_nxt;
  logic [SEPT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SEPT_W-1:0]   held_c_r, held_c_nxt;
  logic                held_v_r, held_v_nxt;
  logic                lim_r, lim_nxt;

  // result buffer
  res_t                res_r [MAX_RES];
  res_t                res_nxt [MAX_RES];
  logic [RCNT_W-1:0]   pend_r;
  logic [RCNT_W-1:0]   n_nxt;
  logic [RIDX_W-1:0]   pos_r;

  logic                in_fire, out_fire;
  logic [WIDE_W-1:0]   lim_w;
  logic [2:0]          bits;
  logic [CHAR_W-1:0]   mask;
  logic [SEPT_W-1:0]   c_char;
  logic [RIDX_W-1:0]   last_idx;

  assign in_ready = (pend_r == '0) || ((pend_r == RCNT_W'(1)) && out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (pend_r != '0);
  assign out_fire  = out_valid && out_ready;

  assign out_character    = res_r[pos_r].character;
  assign out_char_valid   = res_r[pos_r].char_valid;
  assign out_septet_count = res_r[pos_r].septet_count;
  assign out_final_res    = res_r[pos_r].final_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_offset_r  <= '0;
      ussd_mode_r    <= 1'b0;
      septet_limit_r <= LIMIT_RST;
      terminator_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FILL_OFFSET:  fill_offset_r  <= cfg_wdata[2:0];
        CFG_USSD_MODE:    ussd_mode_r    <= cfg_wdata[0];
        CFG_SEPTET_LIMIT: septet_limit_r <= cfg_wdata;
        CFG_TERMINATOR:   terminator_r   <= cfg_wdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [WIDE_W-1:0] lim_cfg;
    logic [RCNT_W-1:0] n;
    logic              hv;
    logic [SEPT_W-1:0] hc;
    logic [CNT_W-1:0]  cnt;
    logic              lr;
    logic [2:0]        bb;
    logic [SEPT_W-1:0] rm;

    lim_cfg = WIDE_W'(septet_limit_r);
    if (!ussd_mode_r && (lim_cfg < MAX_WIDE)) lim_w = lim_cfg;
    else lim_w = MAX_WIDE;

    for (int i = 0; i < MAX_RES; i++) res_nxt[i] = '0;
    n   = '0;
    hv  = held_v_r;
    hc  = held_c_r;
    cnt = cnt_r;
    lr  = lim_r || (WIDE_W'(cnt_r) >= lim_w);
    bb  = budget_r;
    rm  = rem_r;
    first_nxt = first_r;

    bits = first_r ? (3'd7 - ((fill_offset_r == 3'd7) ? 3'd0 : fill_offset_r)) : budget_r;
    if (bits == 3'd0) bits = 3'd7;
    mask   = CHAR_W'((9'd1 << bits) - 9'd1);
    c_char = SEPT_W'((in_octet & mask) << (3'd7 - bits)) | rem_r;

    if (!lr) begin
      rm = SEPT_W'(in_octet >> bits);
      bb = bits;
      if (!first_r || bits == 3'd7) begin
        if (hv) begin
          res_nxt[n[RIDX_W-1:0]] = '{CHAR_W'(hc), 1'b1, '0, 1'b0};
          n = n + RCNT_W'(1);
          hv = 1'b0;
        end
        if (ussd_mode_r) begin
          hc = c_char;
          hv = 1'b1;
        end else begin
          res_nxt[n[RIDX_W-1:0]] = '{CHAR_W'(c_char), 1'b1, '0, 1'b0};
          n = n + RCNT_W'(1);
        end
        cnt = CNT_W'(cnt + 1'b1);
      end
      if (WIDE_W'(cnt) >= lim_w) begin
        lr = 1'b1;
      end else if (bb == 3'd1) begin
        if (hv) begin
          res_nxt[n[RIDX_W-1:0]] = '{CHAR_W'(hc), 1'b1, '0, 1'b0};
          n = n + RCNT_W'(1);
          hv = 1'b0;
        end
        if (ussd_mode_r) begin
          hc = rm;
          hv = 1'b1;
        end else begin
          res_nxt[n[RIDX_W-1:0]] = '{CHAR_W'(rm), 1'b1, '0, 1'b0};
          n = n + RCNT_W'(1);
        end
        cnt = CNT_W'(cnt + 1'b1);
        rm = '0;
        bb = 3'd7;
        if (WIDE_W'(cnt) >= lim_w) lr = 1'b1;
      end else begin
        bb = bb - 3'd1;
      end
      first_nxt = 1'b0;
    end

    last_idx = '0;
    if (in_last_octet) begin
      if (hv) begin
        // CR on an octet boundary is padding, not text
        if (ussd_mode_r && (cnt[2:0] == 3'd0) && (hc == CR_CHAR)) begin
          cnt = CNT_W'(cnt - 1'b1);
        end else begin
          res_nxt[n[RIDX_W-1:0]] = '{CHAR_W'(hc), 1'b1, '0, 1'b0};
          n = n + RCNT_W'(1);
        end
        hv = 1'b0;
      end
      if (terminator_r != '0) begin
        res_nxt[n[RIDX_W-1:0]] = '{terminator_r, 1'b1, '0, 1'b0};
        n = n + RCNT_W'(1);
      end
      if (n == '0) begin
        res_nxt[0] = '{'0, 1'b0, '0, 1'b0};
        n = RCNT_W'(1);
      end
      last_idx = RIDX_W'(n - RCNT_W'(1));
      res_nxt[last_idx].septet_count = COUNT_W'(WIDE_W'(cnt));
      res_nxt[last_idx].final_res    = 1'b1;
      budget_nxt = 3'd7;
      first_nxt  = 1'b1;
      rem_nxt    = '0;
      cnt_nxt    = '0;
      held_c_nxt = '0;
      held_v_nxt = 1'b0;
      lim_nxt    = 1'b0;
    end else begin
      budget_nxt = bb;
      rem_nxt    = rm;
      cnt_nxt    = cnt;
      held_c_nxt = hc;
      held_v_nxt = hv;
      lim_nxt    = lr;
    end
    n_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= 3'd7;
      first_r  <= 1'b1;
      rem_r    <= '0;
      cnt_r    <= '0;
      held_c_r <= '0;
      held_v_r <= 1'b0;
      lim_r    <= 1'b0;
      pend_r   <= '0;
      pos_r    <= '0;
    end else begin
      if (in_fire) begin
        budget_r <= budget_nxt;
        first_r  <= first_nxt;
        rem_r    <= rem_nxt;
        cnt_r    <= cnt_nxt;
        held_c_r <= held_c_nxt;
        held_v_r <= held_v_nxt;
        lim_r    <= lim_nxt;
        pend_r   <= n_nxt;
        pos_r    <= '0;
      end else if (out_fire) begin
        pend_r <= pend_r - RCNT_W'(1);
        pos_r  <= pos_r + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= res_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_last_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_octet) |=> out_valid)
    else $error("last octet produced no result beat");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (WIDE_W'(cnt_r) <= MAX_WIDE))
    else $error("septet count above capacity");

  a_fresh_message: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> ((cnt_r == '0) && !held_v_r))
    else $error("message start with stale state");

  a_final_ends_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_final_res) |-> (pend_r == RCNT_W'(1)))
    else $error("final beat not last in buffer");
`endif

endmodule
`default_nettype wire

FILE: bench/gsm7_result_checker.sv
// Checker for the septet unpacker: predicts result beats and compares them.
`timescale 1ns / 100ps
module gsm7_result_checker #(
  parameter int MAX_SEPTETS = gsm7_pkg::MAX_SEPTETS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [gsm7_pkg::CHAR_W-1:0]      in_octet,
  input  logic                             in_last_octet,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [gsm7_pkg::CHAR_W-1:0]      out_character,
  input  logic                             out_char_valid,
  input  logic [gsm7_pkg::COUNT_W-1:0]     out_septet_count,
  input  logic                             out_final_res,
  input  logic                             cfg_we,
  input  logic [gsm7_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [gsm7_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               pending_results,
  output int                               fail_count,
  output int                               beats_checked
);
  import gsm7_pkg::*;

  logic [2:0]          fill_sh;
  logic                ussd_sh;
  logic [COUNT_W-1:0]  limit_sh;
  logic [CHAR_W-1:0]   term_sh;

  int unsigned         budget_bits;
  bit                  at_msg_start;
  int unsigned         carry;
  int unsigned         sent_count;
  logic [SEPT_W-1:0]   held_sept;
  bit                  held_ok;
  bit                  capped;

  res_t                octet_results[$];
  res_t                char_queue[$];
  int                  errs = 0;
  int                  checked = 0;

  function automatic void start_message();
    budget_bits  = 7 - (int'(fill_sh) % 7);
    at_msg_start = 1'b1;
    carry        = 0;
    sent_count   = 0;
    held_sept    = '0;
    held_ok      = 1'b0;
    capped       = 1'b0;
  endfunction

  function automatic void push_result(input logic [CHAR_W-1:0] ch, input logic vld);
    res_t r;
    r.character    = ch;
    r.char_valid   = vld;
    r.septet_count = '0;
    r.final_res    = 1'b0;
    octet_results.push_back(r);
  endfunction

  // in USSD mode the newest character waits in held_sept for the CR check
  function automatic void emit_septet(input logic [SEPT_W-1:0] sept);
    if (held_ok) begin
      push_result({1'b0, held_sept}, 1'b1);
      held_ok = 1'b0;
    end
    if (ussd_sh) begin
      held_sept = sept;
      held_ok   = 1'b1;
    end else begin
      push_result({1'b0, sept}, 1'b1);
    end
    sent_count++;
  endfunction

  task automatic decode_octet(input logic [CHAR_W-1:0] oct, input logic last);
    int unsigned lim;
    int unsigned nb;
    int unsigned merged;
    res_t        r;
    octet_results.delete();
    lim = MAX_SEPTETS;
    if (!ussd_sh && limit_sh < lim) lim = limit_sh;
    if (sent_count >= lim) capped = 1'b1;
    if (!capped) begin
      nb = at_msg_start ? 7 - (int'(fill_sh) % 7) : budget_bits;
      if (nb < 1 || nb > 7) nb = 7;
      merged = ((int'(oct) & ((1 << nb) - 1)) << (7 - nb)) | carry;
      carry  = (int'(oct) >> nb) & ((1 << (8 - nb)) - 1);
      if (!at_msg_start || nb == 7) emit_septet(merged[6:0]);
      if (sent_count >= lim) begin
        capped = 1'b1;
      end else if (nb == 1) begin
        emit_septet(carry[6:0]);
        carry = 0;
        nb = 7;
        if (sent_count >= lim) capped = 1'b1;
      end else begin
        nb = nb - 1;
      end
      budget_bits  = nb;
      at_msg_start = 1'b0;
    end
    if (last) begin
      if (held_ok) begin
        if (ussd_sh && sent_count % 8 == 0 && held_sept == CR_CHAR) sent_count--;
        else push_result({1'b0, held_sept}, 1'b1);
        held_ok = 1'b0;
      end
      if (term_sh != 0) push_result(term_sh, 1'b1);
      if (octet_results.size() == 0) push_result('0, 1'b0);
      r = octet_results[octet_results.size() - 1];
      r.septet_count = sent_count[COUNT_W-1:0];
      r.final_res    = 1'b1;
      octet_results[octet_results.size() - 1] = r;
      start_message();
    end
    foreach (octet_results[i]) char_queue.push_back(octet_results[i]);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      fill_sh  = '0;
      ussd_sh  = 1'b0;
      limit_sh = LIMIT_RST;
      term_sh  = '0;
      start_message();
      char_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FILL_OFFSET: begin
            fill_sh = cfg_wdata[2:0];
            if (at_msg_start) budget_bits = 7 - (int'(fill_sh) % 7);
          end
          CFG_USSD_MODE:    ussd_sh  = cfg_wdata[0];
          CFG_SEPTET_LIMIT: limit_sh = cfg_wdata[COUNT_W-1:0];
          CFG_TERMINATOR:   term_sh  = cfg_wdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_octet(in_octet, in_last_octet);
      if (out_valid && out_ready) begin
        checked++;
        if (char_queue.size() == 0) begin
          errs++;
          $error("result beat with nothing expected: character %0h final %0b",
                 out_character, out_final_res);
        end else begin
          want = char_queue.pop_front();
          compare_field("character", 16'(want.character), 16'(out_character));
          compare_field("char_valid", 16'(want.char_valid), 16'(out_char_valid));
          compare_field("septet_count", 16'(want.septet_count), 16'(out_septet_count));
          compare_field("final_res", 16'(want.final_res), 16'(out_final_res));
        end
      end
    end
    pending_results <= char_queue.size();
    fail_count      <= errs;
    beats_checked   <= checked;
  end

endmodule

FILE: bench/testbench.sv
// Testbench top: drives octets and register writes into the septet unpacker.
`timescale 1ns / 100ps
module testbench;
  import gsm7_pkg::*;

  localparam int RANDOM_ITEMS = 270;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_octet = '0;
  logic                  in_last_octet = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_char_valid;
  logic [COUNT_W-1:0]    out_septet_count;
  logic                  out_final_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int pending_results;
  int fail_count;
  int beats_checked;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int octets_sent = 0;
  int messages_sent = 0;
  int cycles = 0;

  gsm7_septet_unpacker_top u_top (.*);
  gsm7_result_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_octet(input logic [CHAR_W-1:0] oct, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_octet      <= oct;
    in_last_octet <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    octets_sent++;
    if (last) messages_sent++;
  endtask

  function automatic logic [CHAR_W-1:0] rand_octet();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // cr_tail: last septet of a 7-octet-aligned message is CR (fill offset 0)
  task automatic send_message(input int n, input bit cr_tail);
    logic [CHAR_W-1:0] oct;
    for (int i = 0; i < n; i++) begin
      oct = rand_octet();
      if (cr_tail && i == n - 1) oct = {CR_CHAR, oct[0]};
      send_octet(oct, i == n - 1);
    end
  endtask

  task automatic apply_settings(input logic [2:0] fill, input logic ussd,
                                input logic [COUNT_W-1:0] lim, input logic [CHAR_W-1:0] term);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FILL_OFFSET;
    cfg_wdata <= {10'b0, fill};
    @(posedge clk);
    cfg_addr  <= CFG_USSD_MODE;
    cfg_wdata <= {12'b0, ussd};
    @(posedge clk);
    cfg_addr  <= CFG_SEPTET_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_addr  <= CFG_TERMINATOR;
    cfg_wdata <= {5'b0, term};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [CHAR_W-1:0]  corner_oct[7];
    logic [2:0]         fill;
    logic               ussd;
    logic [COUNT_W-1:0] lim;
    logic [CHAR_W-1:0]  term;
    int                 random_start;
    int                 phase;
    int                 len;
    bit                 cr_tail;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: one full 7-octet group of corner values
    corner_oct = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55};
    foreach (corner_oct[i]) send_octet(corner_oct[i], i == 6);
    wait_idle();

    // fill offset seven acts as zero; USSD final CR dropped; terminator 0xFF
    apply_settings(3'd7, 1'b1, 13'h1FFF, 8'hFF);
    send_message(7, 1'b1);
    wait_idle();

    // zero limit: bare end marker
    apply_settings(3'd6, 1'b0, 13'd0, 8'h00);
    send_octet(8'hFF, 1'b1);
    wait_idle();

    // fill six: first octet yields only the septet in its top seven bits
    apply_settings(3'd6, 1'b1, 13'h1FFF, 8'h00);
    send_octet(8'h81, 1'b1);
    wait_idle();

    // no character at all in USSD mode: nothing held at the end
    apply_settings(3'd3, 1'b1, 13'h1FFF, 8'h00);
    send_octet(8'h1A, 1'b1);
    wait_idle();

    // mode and limit change inside a message, fill change for the next one
    apply_settings(3'd0, 1'b1, 13'h1FFF, 8'h40);
    send_message(0, 1'b0);
    for (int i = 0; i < 3; i++) send_octet(rand_octet(), 1'b0);
    wait_idle();
    apply_settings(3'd2, 1'b0, 13'd2, 8'h40);
    send_octet(rand_octet(), 1'b0);
    send_octet(rand_octet(), 1'b1);
    send_message(3, 1'b0);
    wait_idle();

    random_start = octets_sent;
    phase = 0;
    while (octets_sent - random_start < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 72; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      fill = 3'($urandom_range(7));
      ussd = 1'($urandom_range(1));
      case ($urandom_range(3))
        0:       lim = 13'd0;
        1:       lim = 13'($urandom_range(24, 1));
        2:       lim = 13'($urandom_range(8191));
        default: lim = LIMIT_RST;
      endcase
      term = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
      apply_settings(fill, ussd, lim, term);
      if (phase % 8 == 0) hold_asked <= hold_asked + 1;
      repeat ($urandom_range(5, 2)) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 11) : $urandom_range(10, 1);
        cr_tail = ussd && (fill % 7 == 0) && ($urandom_range(2) == 0);
        if (cr_tail) len = 7 * $urandom_range(2, 1);
        send_message(len, cr_tail);
      end
      // leave a message open across the next register change
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(4, 1)) send_octet(rand_octet(), 1'b0);
      end
      wait_idle();
      phase++;
    end
    send_octet(rand_octet(), 1'b1);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("ran %0d octets in %0d messages over %0d random phases, %0d result beats checked",
             octets_sent, messages_sent, phase, beats_checked);
    $display("swept fill offsets, USSD on and off, limits from zero up, idle and stall mixes");
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
